// ----- rtl/core/jdht_pkg.sv -----
`default_nettype none

package jdht_pkg;

  localparam int unsigned NUM_LENGTHS_DEF = 16;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CODE_W = 16;
  localparam int unsigned LEN_W  = 5;
  localparam int unsigned SKIP_W = 3;

  localparam logic [BYTE_W-1:0] MARKER_PREFIX = 8'hFF;
  localparam logic [BYTE_W-1:0] MARKER_DHT    = 8'hC4;

  // header bytes passed over before each table's counts
  localparam logic [SKIP_W-1:0] DC_SKIP = 3'd3;
  localparam logic [SKIP_W-1:0] AC_SKIP = 3'd5;

  localparam logic CLASS_DC = 1'b0;
  localparam logic CLASS_AC = 1'b1;

  typedef enum logic [1:0] {
    PH_SCAN,
    PH_SKIP,
    PH_COUNTS,
    PH_SYMBOLS
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic              table_class;
    logic              last_of_table;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/jdht_ifs.sv -----
`default_nettype none

interface jdht_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

interface jdht_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  symbol;
  logic [15:0] code_bits;
  logic [4:0]  code_length;
  logic        table_class;
  logic        last_of_table;

  modport source (output valid, output symbol, output code_bits, output code_length,
                  output table_class, output last_of_table, input ready);
  modport sink   (input valid, input symbol, input code_bits, input code_length,
                  input table_class, input last_of_table, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/jdht_seek.sv -----
`default_nettype none

// Priority search: lowest set mask bit at or above start.
module jdht_seek import jdht_pkg::*; #(
  parameter int unsigned NUM_LENGTHS = NUM_LENGTHS_DEF
) (
  input  logic [NUM_LENGTHS-1:0]          mask,
  input  logic [$clog2(NUM_LENGTHS):0]    start,
  output logic                            hit,
  output logic [$clog2(NUM_LENGTHS)-1:0]  idx
);

  localparam int unsigned IDX_W = $clog2(NUM_LENGTHS);
  localparam int unsigned POS_W = IDX_W + 1;

  always_comb begin
    hit = 1'b0;
    idx = '0;
    for (int i = NUM_LENGTHS - 1; i >= 0; i--) begin
      if (mask[i] && (POS_W'(i) >= start)) begin
        hit = 1'b1;
        idx = IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/jpeg_dht_canonical_huffman_codes_core.sv -----
// Path: a word accepted on stream passes the input register, then the result
//   register, before its entry is on result; a result stall holds it there.
// Throughput: one word per cycle in every phase; a waiting result stalls input only
//   when the word in the input register would itself produce an entry.
// Reset (rst, synchronous): marker scan, DC class, empty pipeline; the stored length
//   counts are not cleared, each is rewritten before it is read.
`default_nettype none

module jpeg_dht_canonical_huffman_codes_core import jdht_pkg::*; #(
  parameter int unsigned NUM_LENGTHS = NUM_LENGTHS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  jdht_byte_if.sink     stream,
  jdht_result_if.source result
);

  localparam int unsigned IDX_W = $clog2(NUM_LENGTHS);
  localparam int unsigned POS_W = IDX_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LENGTHS - 1);

  // ---------------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------------
  logic              stage_valid;
  logic [BYTE_W-1:0] stage_byte;
  logic              stage_go;
  logic              step;

  // ---------------------------------------------------------------------------
  // parser state
  // ---------------------------------------------------------------------------
  phase_t            phase, phase_next;
  logic              saw_prefix, saw_prefix_next;
  logic [SKIP_W-1:0] skip_left, skip_left_next;
  logic [BYTE_W-1:0] counts [NUM_LENGTHS];
  logic [IDX_W-1:0]  count_index, count_index_next;
  logic [BYTE_W-1:0] symbols_left, symbols_left_next;
  logic [CODE_W-1:0] running_code, running_code_next;
  logic [LEN_W-1:0]  current_length, current_length_next;
  logic              current_class, current_class_next;

  // result register
  logic              res_valid;
  result_t           res, res_next;
  logic              emit;

  // ---------------------------------------------------------------------------
  // handshake: result register frees on take, input register on step
  // ---------------------------------------------------------------------------
  assign emit     = (phase == PH_SYMBOLS);
  assign stage_go = !emit || !res_valid || result.ready;
  assign step     = stage_valid && stage_go;
  assign stream.ready = !stage_valid || stage_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (stream.ready) begin
      stage_valid <= stream.valid;
    end
    if (stream.ready && stream.valid) begin
      stage_byte <= stream.stream_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // zero-count skip: one priority search serves the end of the counts and the
  // end of each length's symbols
  // ---------------------------------------------------------------------------
  logic                   last_count;
  logic [NUM_LENGTHS-1:0] nz_mask;
  logic [POS_W-1:0]       seek_start;
  logic                   seek_hit;
  logic [IDX_W-1:0]       seek_idx;
  logic [BYTE_W-1:0]      seek_count;
  logic [BYTE_W-1:0]      left_dec;
  logic                   left_done;
  logic [POS_W-1:0]       shift;

  assign last_count = (phase == PH_COUNTS) && (count_index == LAST_IDX);

  // the final count is still in the input register when the search runs
  always_comb begin
    for (int i = 0; i < NUM_LENGTHS; i++) begin
      if (last_count && (IDX_W'(i) == LAST_IDX)) begin
        nz_mask[i] = (stage_byte != '0);
      end else begin
        nz_mask[i] = (counts[i] != '0);
      end
    end
  end

  assign seek_start = (phase == PH_COUNTS) ? '0 : (POS_W'(count_index) + POS_W'(1));

  jdht_seek #(
    .NUM_LENGTHS (NUM_LENGTHS)
  ) u_seek (
    .mask  (nz_mask),
    .start (seek_start),
    .hit   (seek_hit),
    .idx   (seek_idx)
  );

  assign seek_count = (last_count && (seek_idx == LAST_IDX)) ? stage_byte : counts[seek_idx];
  assign left_dec   = (symbols_left != '0) ? (symbols_left - BYTE_W'(1)) : '0;
  assign left_done  = (left_dec == '0);
  // lengths advanced in this step: the finished one plus every empty one passed
  assign shift      = POS_W'(seek_idx) - POS_W'(count_index);

  // ---------------------------------------------------------------------------
  // phase sequencing
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_SCAN: begin
        if (saw_prefix && (stage_byte == MARKER_DHT)) begin
          phase_next = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (skip_left <= SKIP_W'(1)) begin
          phase_next = PH_COUNTS;
        end
      end
      PH_COUNTS: begin
        if (last_count) begin
          if (seek_hit) begin
            phase_next = PH_SYMBOLS;
          end else if (current_class == CLASS_DC) begin
            phase_next = PH_SKIP;
          end else begin
            phase_next = PH_SCAN;
          end
        end
      end
      PH_SYMBOLS: begin
        if (left_done && !seek_hit) begin
          phase_next = (current_class == CLASS_DC) ? PH_SKIP : PH_SCAN;
        end
      end
      default: phase_next = PH_SCAN;
    endcase
  end

  // ---------------------------------------------------------------------------
  // datapath and result
  // ---------------------------------------------------------------------------
  always_comb begin
    saw_prefix_next     = saw_prefix;
    skip_left_next      = skip_left;
    count_index_next    = count_index;
    symbols_left_next   = symbols_left;
    running_code_next   = running_code;
    current_length_next = current_length;
    current_class_next  = current_class;

    res_next.symbol        = stage_byte;
    res_next.code_bits     = running_code;
    res_next.code_length   = current_length;
    res_next.table_class   = current_class;
    res_next.last_of_table = left_done && !seek_hit;

    case (phase)
      PH_SCAN: begin
        if (saw_prefix) begin
          saw_prefix_next = 1'b0;
          if (stage_byte == MARKER_DHT) begin
            current_class_next = CLASS_DC;
            skip_left_next     = DC_SKIP;
          end
        end else if (stage_byte == MARKER_PREFIX) begin
          saw_prefix_next = 1'b1;
        end
      end
      PH_SKIP: begin
        if (skip_left != '0) begin
          skip_left_next = skip_left - SKIP_W'(1);
        end
        if (skip_left <= SKIP_W'(1)) begin
          count_index_next = '0;
        end
      end
      PH_COUNTS: begin
        if (last_count) begin
          // code starts at zero: the empty lengths passed only lengthen it
          running_code_next   = '0;
          current_length_next = LEN_W'(seek_idx) + LEN_W'(1);
          count_index_next    = seek_idx;
          if (seek_hit) begin
            symbols_left_next = seek_count;
          end else if (current_class == CLASS_DC) begin
            current_class_next = CLASS_AC;
            skip_left_next     = AC_SKIP;
          end else begin
            current_class_next = CLASS_DC;
            saw_prefix_next    = 1'b0;
          end
        end else begin
          count_index_next = count_index + IDX_W'(1);
        end
      end
      PH_SYMBOLS: begin
        symbols_left_next = left_dec;
        running_code_next = running_code + CODE_W'(1);
        if (left_done) begin
          if (seek_hit) begin
            running_code_next   = CODE_W'((running_code + CODE_W'(1)) << shift);
            current_length_next = current_length + LEN_W'(shift);
            count_index_next    = seek_idx;
            symbols_left_next   = seek_count;
          end else if (current_class == CLASS_DC) begin
            current_class_next = CLASS_AC;
            skip_left_next     = AC_SKIP;
          end else begin
            current_class_next = CLASS_DC;
            saw_prefix_next    = 1'b0;
          end
        end
      end
      default: begin
        saw_prefix_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SCAN;
      saw_prefix     <= 1'b0;
      skip_left      <= '0;
      count_index    <= '0;
      symbols_left   <= '0;
      running_code   <= '0;
      current_length <= LEN_W'(1);
      current_class  <= CLASS_DC;
    end else if (step) begin
      phase          <= phase_next;
      saw_prefix     <= saw_prefix_next;
      skip_left      <= skip_left_next;
      count_index    <= count_index_next;
      symbols_left   <= symbols_left_next;
      running_code   <= running_code_next;
      current_length <= current_length_next;
      current_class  <= current_class_next;
    end
  end

  // count store: one write per counts word, no reset
  always_ff @(posedge clk) begin
    if (step && (phase == PH_COUNTS)) begin
      counts[count_index] <= stage_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step && emit) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
    if (step && emit) begin
      res <= res_next;
    end
  end

  assign result.valid         = res_valid;
  assign result.symbol        = res.symbol;
  assign result.code_bits     = res.code_bits;
  assign result.code_length   = res.code_length;
  assign result.table_class   = res.table_class;
  assign result.last_of_table = res.last_of_table;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_symbols_pending: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SYMBOLS) |-> (symbols_left != '0))
    else $error("symbol phase with no symbols left");

  a_length_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SYMBOLS) |->
      ((current_length != '0) && (current_length <= LEN_W'(NUM_LENGTHS))))
    else $error("code length out of range");

  a_skip_pending: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SKIP) |-> (skip_left != '0))
    else $error("skip phase with nothing to skip");

  a_prefix_in_scan: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_SCAN) |-> !saw_prefix)
    else $error("marker prefix held outside scan");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (step && emit) |=> res_valid)
    else $error("symbol word did not load the result register");

endmodule

`default_nettype wire

// ----- sim/jdht_entry_checker.sv -----
`default_nettype none

// Watches both channels, predicts the code entry for each accepted symbol word
// and compares accepted entries against the oldest prediction.
module jdht_entry_checker import jdht_pkg::*; #(
  parameter int unsigned NUM_LENGTHS = NUM_LENGTHS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    stream_valid,
  input  logic    stream_ready,
  input  logic [BYTE_W-1:0] stream_byte,
  input  logic    result_valid,
  input  logic    result_ready,
  input  result_t result_word,
  output int      failures,
  output int      pending,
  output int      words_seen,
  output int      entries_seen,
  output int      dc_entries,
  output int      last_flags
);

  // predictor state
  phase_t            ph;
  bit                prefix_seen;
  logic [SKIP_W-1:0] skip_left;
  logic [BYTE_W-1:0] len_counts [16];
  int unsigned       len_idx;
  logic [BYTE_W-1:0] syms_left;
  logic [CODE_W-1:0] next_code;
  logic [LEN_W-1:0]  next_len;
  logic              cur_class;

  result_t entry_q [$];
  int      n_fail, n_words, n_entries, n_dc, n_last;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] entry %0d: %s got 0x%0h, expected 0x%0h",
             $time, n_entries, what, got, want);
    n_fail++;
  endtask

  // skip zero counts; code doubles for every length passed over
  function automatic bit find_used_length();
    while (len_idx < NUM_LENGTHS && len_idx < 16) begin
      if (len_counts[4'(len_idx)] != 0) begin
        syms_left = len_counts[4'(len_idx)];
        return 1'b1;
      end
      next_code = next_code << 1;
      next_len  = next_len + LEN_W'(1);
      len_idx++;
    end
    return 1'b0;
  endfunction

  function automatic void close_table();
    if (cur_class == CLASS_DC) begin
      cur_class = CLASS_AC;
      skip_left = AC_SKIP;
      ph        = PH_SKIP;
    end else begin
      cur_class   = CLASS_DC;
      prefix_seen = 1'b0;
      ph          = PH_SCAN;
    end
  endfunction

  task automatic predict_entry(input logic [BYTE_W-1:0] b);
    result_t e;
    bit      last;
    case (ph)
      PH_SCAN: begin
        if (prefix_seen) begin
          prefix_seen = 1'b0;
          if (b == MARKER_DHT) begin
            cur_class = CLASS_DC;
            skip_left = DC_SKIP;
            ph        = PH_SKIP;
          end
        end else if (b == MARKER_PREFIX) begin
          prefix_seen = 1'b1;
        end
      end
      PH_SKIP: begin
        if (skip_left != 0) skip_left = skip_left - SKIP_W'(1);
        if (skip_left == 0) begin
          len_idx = 0;
          ph      = PH_COUNTS;
        end
      end
      PH_COUNTS: begin
        len_counts[4'(len_idx)] = b;
        if (len_idx + 1 >= NUM_LENGTHS || len_idx >= 15) begin
          len_idx   = 0;
          next_code = '0;
          next_len  = LEN_W'(1);
          if (find_used_length()) ph = PH_SYMBOLS;
          else close_table();
        end else begin
          len_idx++;
        end
      end
      PH_SYMBOLS: begin
        e.symbol      = b;
        e.code_bits   = next_code;
        e.code_length = next_len;
        e.table_class = cur_class;
        last          = 1'b0;
        next_code     = next_code + CODE_W'(1);
        if (syms_left != 0) syms_left = syms_left - BYTE_W'(1);
        if (syms_left == 0) begin
          next_code = next_code << 1;
          next_len  = next_len + LEN_W'(1);
          len_idx++;
          if (!find_used_length()) begin
            last = 1'b1;
            close_table();
          end
        end
        e.last_of_table = last;
        entry_q.push_back(e);
      end
      default: begin
        ph          = PH_SCAN;
        prefix_seen = 1'b0;
      end
    endcase
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      ph          = PH_SCAN;
      prefix_seen = 1'b0;
      skip_left   = '0;
      len_idx     = 0;
      syms_left   = '0;
      next_code   = '0;
      next_len    = LEN_W'(1);
      cur_class   = CLASS_DC;
      entry_q.delete();
      n_fail = 0; n_words = 0; n_entries = 0; n_dc = 0; n_last = 0;
    end else begin
      // entries first: a word accepted at this edge cannot show up at it
      if (result_valid && result_ready) begin
        if (entry_q.size() == 0) begin
          report_mismatch("unexpected entry, symbol", result_word.symbol, 0);
        end else begin
          want = entry_q.pop_front();
          if (result_word.symbol != want.symbol)
            report_mismatch("symbol", result_word.symbol, want.symbol);
          if (result_word.code_bits != want.code_bits)
            report_mismatch("code_bits", result_word.code_bits, want.code_bits);
          if (result_word.code_length != want.code_length)
            report_mismatch("code_length", result_word.code_length, want.code_length);
          if (result_word.table_class != want.table_class)
            report_mismatch("table_class", result_word.table_class, want.table_class);
          if (result_word.last_of_table != want.last_of_table)
            report_mismatch("last_of_table", result_word.last_of_table,
                            want.last_of_table);
        end
        n_entries++;
        if (result_word.table_class == CLASS_DC) n_dc++;
        if (result_word.last_of_table) n_last++;
      end
      if (stream_valid && stream_ready) begin
        predict_entry(stream_byte);
        n_words++;
      end
    end
    failures     <= n_fail;
    pending      <= entry_q.size();
    words_seen   <= n_words;
    entries_seen <= n_entries;
    dc_entries   <= n_dc;
    last_flags   <= n_last;
  end

endmodule

`default_nettype wire

// ----- sim/tb_jpeg_dht_canonical_huffman_codes_core.sv -----
`default_nettype none

// Stimulus and verdict for the DHT code generator. The checker beside the block
// does all prediction and comparison; this module only feeds words in, pulls
// entries out, and decides pass or fail.
module tb_jpeg_dht_canonical_huffman_codes_core;
  import jdht_pkg::*;

  localparam int RANDOM_WORDS = 1900;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_LIMIT  = 4000;

  // Directed opening: false markers, marker bytes inside the header skips, a
  // DC table whose codes wrap at 16 bits (two length-1 codes, then one of
  // length 16 which lands on zero) with 0xFF/0x00/0xC4 as symbols, then an
  // all-zero AC table which must give nothing and drop back to the scan.
  localparam int N_DIRECTED = 50;
  localparam logic [7:0] DIRECTED [N_DIRECTED] = '{
    8'hFF, 8'h00,                              // 0xFF then a non-marker byte
    8'hFF, 8'hFF, 8'hC4,                       // second 0xFF is consumed, no marker
    8'hFF, 8'hC4,                              // real marker
    8'hFF, 8'hC4, 8'h00,                       // DC header skip
    8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
    8'hFF, 8'h00, 8'hC4,                       // DC symbols
    8'hFF, 8'hC4, 8'hFF, 8'hC4, 8'hFF,         // AC header skip
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  jdht_byte_if   stream_if ();
  jdht_result_if result_if ();

  result_t result_word;
  int      failures, pending, words_seen, entries_seen, dc_entries, last_flags;
  int      holds_done;

  logic [7:0] word_plan [$];

  always #2 clk = ~clk;

  jpeg_dht_canonical_huffman_codes_core u_top (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_if),
    .result (result_if)
  );

  assign result_word = {result_if.symbol, result_if.code_bits, result_if.code_length,
                        result_if.table_class, result_if.last_of_table};

  jdht_entry_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .stream_valid (stream_if.valid),
    .stream_ready (stream_if.ready),
    .stream_byte  (stream_if.stream_byte),
    .result_valid (result_if.valid),
    .result_ready (result_if.ready),
    .result_word  (result_word),
    .failures     (failures),
    .pending      (pending),
    .words_seen   (words_seen),
    .entries_seen (entries_seen),
    .dc_entries   (dc_entries),
    .last_flags   (last_flags)
  );

  // Watchdog: well beyond the slowest legal run (every word behind a long
  // sender gap and a long receiver stall, plus both hold-offs).
  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Plan building
  // ---------------------------------------------------------------------------

  // symbols lean on the marker values, which must pass as plain data here
  function automatic logic [7:0] pick_symbol();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return MARKER_PREFIX;
    if (r == 1) return MARKER_DHT;
    return 8'($urandom);
  endfunction

  // 16 counts then the symbols they call for. Mostly sparse small counts; now
  // and then an empty table or one long run at a single length.
  function automatic void plan_table();
    logic [7:0] cnt [16];
    int         total, mode, big_at;
    mode   = $urandom_range(0, 19);
    big_at = $urandom_range(0, 15);
    total  = 0;
    for (int i = 0; i < 16; i++) begin
      if (mode < 3)
        cnt[i] = 8'd0;
      else if (mode == 3)
        cnt[i] = (i == big_at) ? 8'($urandom_range(16, 160)) : 8'd0;
      else
        cnt[i] = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 4)) : 8'd0;
      total += cnt[i];
      word_plan.push_back(cnt[i]);
    end
    for (int i = 0; i < total; i++) word_plan.push_back(pick_symbol());
  endfunction

  // A whole DHT segment: short lead-in with no 0xFF, marker, DC table, AC table.
  function automatic void plan_segment();
    int lead;
    lead = $urandom_range(0, 3);
    for (int i = 0; i < lead; i++) word_plan.push_back(8'($urandom_range(0, 254)));
    word_plan.push_back(MARKER_PREFIX);
    word_plan.push_back(MARKER_DHT);
    for (int i = 0; i < DC_SKIP; i++) word_plan.push_back(8'($urandom));
    plan_table();
    for (int i = 0; i < AC_SKIP; i++) word_plan.push_back(8'($urandom));
    plan_table();
  endfunction

  // Noise and broken markers. 0xC4 only ever follows a consumed 0xFF here,
  // and a trailing 0x00 keeps a stray prefix off the next segment's marker.
  function automatic void plan_noise();
    int kind, n;
    kind = $urandom_range(0, 2);
    case (kind)
      0: begin
        n = $urandom_range(4, 20);
        for (int i = 0; i < n; i++)
          word_plan.push_back(($urandom_range(0, 2) == 0) ? MARKER_PREFIX
                                                           : 8'($urandom_range(0, 8'hC3)));
      end
      1: begin
        word_plan.push_back(MARKER_PREFIX);
        word_plan.push_back(($urandom_range(0, 1) == 0) ? MARKER_PREFIX
                                                         : 8'($urandom_range(0, 8'hC3)));
      end
      default: begin
        word_plan.push_back(MARKER_PREFIX);
        word_plan.push_back(MARKER_PREFIX);
        word_plan.push_back(MARKER_DHT);
      end
    endcase
    word_plan.push_back(8'h00);
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // mostly back to back, some short gaps, a few long; every fourth stretch of
  // 80 words goes without any gap at all
  function automatic int pick_gap(input int idx);
    int r;
    if ((idx / 80) % 4 == 2) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Entered and left at a falling edge; valid stays high between words unless
  // a gap is taken, so it is never lowered and raised in one step.
  task automatic send_word(input logic [7:0] b, input int idx);
    int gap;
    gap = pick_gap(idx);
    if (gap > 0) begin
      stream_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    stream_if.valid       <= 1'b1;
    stream_if.stream_byte <= b;
    @(posedge clk);
    while (!stream_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Receiver: random stalls with stall-free stretches, plus two long hold-offs
  // while the sender keeps offering, so the block backs up and stalls its
  // input. The hold length is counted here, not tied to any handshake.
  initial begin
    int stall_left, r, cycle;
    stall_left = 0;
    cycle      = 0;
    holds_done = 0;
    result_if.ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      cycle++;
      if ((holds_done == 0 && entries_seen >= 15) ||
          (holds_done == 1 && entries_seen >= 500)) begin
        result_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end else if (stall_left > 0) begin
        result_if.ready <= 1'b0;
        stall_left--;
      end else if ((cycle / 256) % 4 == 1) begin
        result_if.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          result_if.ready <= 1'b1;
        end else if (r < 95) begin
          result_if.ready <= 1'b0;
          stall_left = $urandom_range(0, 2);
        end else begin
          result_if.ready <= 1'b0;
          stall_left = $urandom_range(10, 30);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int left_over;
    stream_if.valid       = 1'b0;
    stream_if.stream_byte = 8'h00;

    for (int i = 0; i < N_DIRECTED; i++) word_plan.push_back(DIRECTED[i]);
    // random part: four in five are well-formed segments
    while (word_plan.size() < N_DIRECTED + RANDOM_WORDS) begin
      if ($urandom_range(0, 4) == 0) plan_noise();
      else plan_segment();
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < word_plan.size(); i++) send_word(word_plan[i], i);
    stream_if.valid <= 1'b0;

    // drain, then let the two-stage pipeline settle
    for (int i = 0; i < DRAIN_LIMIT && pending != 0; i++) @(posedge clk);
    repeat (8) @(posedge clk);

    left_over = pending;
    if (left_over != 0)
      $display("%0d expected entries never came out", left_over);

    $display("Fed %0d stream words through DHT segments and noise; %0d entries",
             words_seen, entries_seen);
    $display("checked (%0d DC, %0d AC, %0d table ends), %0d receiver hold-offs",
             dc_entries, entries_seen - dc_entries, last_flags, holds_done);
    if (failures == 0 && left_over == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
